// ===== rtl/core/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg
// shared types, constants and helpers of the 3x3 linear solver
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int ACC_W       = 3 * FIELD_W + 3;
  localparam int NUM_W       = ACC_W + FRAC_BITS;
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_AW     = $clog2(JOBQ_DEPTH);

  localparam logic [1:0] CMD_SOLVE  = 2'd0;
  localparam logic [1:0] CMD_INVERT = 2'd1;
  localparam logic [1:0] CMD_DET    = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SINGULAR = 2'd1;
  localparam logic [1:0] STAT_SAT      = 2'd2;

  localparam logic [1:0] COL_RHS = 2'd3;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [FIELD_W-1:0] coef_col0;
    logic signed [FIELD_W-1:0] coef_col1;
    logic signed [FIELD_W-1:0] coef_col2;
    logic signed [FIELD_W-1:0] rhs_value;
    logic                      last_row;
  } sls_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value0;
    logic signed [FIELD_W-1:0] value1;
    logic signed [FIELD_W-1:0] value2;
    logic [1:0]                status;
    logic                      last_result;
  } sls_out_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] c0;
    logic signed [FIELD_W-1:0] c1;
    logic signed [FIELD_W-1:0] c2;
    logic signed [FIELD_W-1:0] rhs;
  } sls_row_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
  } sls_job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [ACC_W-1:0] den;
  } sls_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } sls_div_rsp_t;

  typedef struct packed {
    logic               flag;
    logic [FIELD_W-1:0] value;
  } sls_sat_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_RDX, BK_RDY, BK_MUL1, BK_MUL2, BK_ACC2, BK_MUL3, BK_ACC3,
    BK_ACCP, BK_TERM, BK_CHECK, BK_DIV, BK_DIVW, BK_STORE, BK_EMIT
  } sls_bk_state_e;

  function automatic logic signed [FIELD_W-1:0] take_entry(logic [FIELD_W-1:0] raw);
    logic signed [ENTRY_WIDTH-1:0] v;
    v = raw[ENTRY_WIDTH-1:0];
    return FIELD_W'(v);
  endfunction

  function automatic sls_sat_t sat_mag(logic [NUM_W-1:0] mag, logic neg);
    logic [NUM_W-1:0] lim;
    logic [NUM_W-1:0] tmp;
    sls_sat_t         r;
    lim = NUM_W'(1) << (ENTRY_WIDTH - 1);
    r.flag = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        tmp    = -lim;
        r.flag = 1'b1;
      end else begin
        tmp = -mag;
      end
    end else begin
      if (mag > lim - NUM_W'(1)) begin
        tmp    = lim - NUM_W'(1);
        r.flag = 1'b1;
      end else begin
        tmp = mag;
      end
    end
    r.value = tmp[FIELD_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/linear_solver_3x3.sv =====
// ----------------------------------------------------------------------------
// linear_solver_3x3
// 3x3 solve, inverse and determinant in signed Q16.16 by Cramer's rule
// ----------------------------------------------------------------------------
// rows are taken while busy is low; a command starts after its last row
// the determinant runs through the shared 33x33 multiplier; solve adds three
// divisions and inverse nine, each in the bit-serial divider
// busy stays high until the last result has left; results are not stalled
// reset clears the row counter, the command queue and the sequencer
module linear_solver_3x3 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  sls_pkg::sls_in_t  item_i,
  output logic              busy,
  output sls_pkg::sls_out_t result_o,
  output logic              strobe
);

  sls_pkg::sls_job_t     job;
  sls_pkg::sls_row_t     rd_data;
  sls_pkg::sls_div_req_t div_req;
  sls_pkg::sls_div_rsp_t div_rsp;
  logic [1:0]            rd_addr;
  logic                  pop;
  logic                  back_busy;
  logic                  accept;

  assign busy   = job.valid || back_busy;
  assign accept = start && !busy;

  sls_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .job_o     (job),
    .pop_i     (pop)
  );

  sls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sls_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .pop_o     (pop),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .busy_o    (back_busy),
    .result_o  (result_o),
    .strobe_o  (strobe)
  );

endmodule

// ===== rtl/core/sls_div.sv =====
// ----------------------------------------------------------------------------
// sls_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sls_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sls_pkg::sls_div_req_t req_i,
  output sls_pkg::sls_div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(sls_pkg::NUM_W + 1);

  logic                      busy_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [sls_pkg::ACC_W-1:0] rem_q;
  logic [sls_pkg::ACC_W-1:0] den_q;
  logic [sls_pkg::NUM_W-1:0] quo_q;
  logic [sls_pkg::ACC_W:0]   rem_sh;
  logic [sls_pkg::ACC_W:0]   diff;
  logic                      ge;

  assign rem_sh = {rem_q, quo_q[sls_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = ~diff[sls_pkg::ACC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(sls_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[sls_pkg::ACC_W-1:0] : rem_sh[sls_pkg::ACC_W-1:0];
      quo_q <= {quo_q[sls_pkg::NUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/core/sls_front.sv =====
// ----------------------------------------------------------------------------
// sls_front
// row capture, row store and command queue
// ----------------------------------------------------------------------------
module sls_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sls_pkg::sls_in_t  item_i,
  input  logic [1:0]        rd_addr_i,
  output sls_pkg::sls_row_t rd_data_o,
  output sls_pkg::sls_job_t job_o,
  input  logic              pop_i
);

  sls_pkg::sls_row_t              mem_q [3];
  sls_pkg::sls_row_t              rd_q;
  logic [1:0]                     row_cnt_q;
  logic [1:0]                     jq_q [sls_pkg::JOBQ_DEPTH];
  logic [sls_pkg::JOBQ_AW-1:0]    wr_ptr_q;
  logic [sls_pkg::JOBQ_AW-1:0]    rd_ptr_q;
  logic [sls_pkg::JOBQ_AW:0]      cnt_q;
  logic                           push;
  sls_pkg::sls_row_t              wr_row;

  assign push = accept_i && item_i.last_row && (item_i.command != sls_pkg::CMD_NONE);

  always_comb begin
    wr_row.c0  = sls_pkg::take_entry(item_i.coef_col0);
    wr_row.c1  = sls_pkg::take_entry(item_i.coef_col1);
    wr_row.c2  = sls_pkg::take_entry(item_i.coef_col2);
    wr_row.rhs = sls_pkg::take_entry(item_i.rhs_value);
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem_q[row_cnt_q] <= wr_row;
    end
    rd_q <= mem_q[rd_addr_i];
    if (push) begin
      jq_q[wr_ptr_q] <= item_i.command;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (accept_i) begin
        if (item_i.last_row) begin
          row_cnt_q <= '0;
        end else if (row_cnt_q != 2'd2) begin
          row_cnt_q <= row_cnt_q + 2'd1;
        end
      end
      if (push) begin
        wr_ptr_q <= wr_ptr_q + sls_pkg::JOBQ_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + sls_pkg::JOBQ_AW'(1);
      end
      cnt_q <= cnt_q + (sls_pkg::JOBQ_AW+1)'(push) - (sls_pkg::JOBQ_AW+1)'(pop_i);
    end
  end

  assign rd_data_o = rd_q;
  assign job_o.valid = (cnt_q != '0);
  assign job_o.cmd   = jq_q[rd_ptr_q];

endmodule

// ===== rtl/core/sls_back.sv =====
// ----------------------------------------------------------------------------
// sls_back
// determinant, cofactor and quotient sequencer with one shared multiplier
// ----------------------------------------------------------------------------
module sls_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sls_pkg::sls_job_t     job_i,
  output logic                  pop_o,
  output logic [1:0]            rd_addr_o,
  input  sls_pkg::sls_row_t     rd_data_i,
  output sls_pkg::sls_div_req_t div_req_o,
  input  sls_pkg::sls_div_rsp_t div_rsp_i,
  output logic                  busy_o,
  output sls_pkg::sls_out_t     result_o,
  output logic                  strobe_o
);

  localparam int AW = sls_pkg::ACC_W;
  localparam int FW = sls_pkg::FIELD_W;

  // column of row n for each permutation term, and its sign
  localparam logic [1:0] PERM [6][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd0}
  };
  localparam logic PERM_NEG [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

  sls_pkg::sls_bk_state_e state_q, state_d;

  logic [1:0]                 cmd_q;
  logic                       num_phase_q;
  logic                       sing_q;
  logic                       flag_q;
  logic [2:0]                 term_q;
  logic [1:0]                 kcol_q;
  logic [1:0]                 irow_q;
  logic signed [FW:0]         opa_q;
  logic signed [2*FW-1:0]     p_q;
  logic signed [2*FW+1:0]     m_q;
  logic signed [AW-1:0]       acc_q;
  logic signed [AW-1:0]       det_q;
  logic [FW-1:0]              vals_q [3];
  sls_pkg::sls_out_t          res_q;
  logic                       strobe_q;

  logic                       pair;
  logic                       last_term;
  logic [1:0]                 op_row [3];
  logic [1:0]                 op_col [3];
  logic                       neg;
  logic [1:0]                 r1, r2, c1, c2;
  logic [1:0]                 pick_col;
  logic signed [FW-1:0]       pick;
  logic signed [FW:0]         mul_a, mul_b;
  logic signed [2*FW+1:0]     mul_p;
  logic signed [AW-1:0]       addend;
  logic [AW-1:0]              abs_acc;
  logic [AW-1:0]              abs_det;
  logic                       emit_last;
  sls_pkg::sls_sat_t          div_sat;
  sls_pkg::sls_sat_t          det_sat;

  assign pair      = num_phase_q && (cmd_q == sls_pkg::CMD_INVERT);
  assign last_term = pair ? (term_q == 3'd1) : (term_q == 3'd5);
  assign abs_acc   = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign abs_det   = det_q[AW-1] ? AW'(-det_q) : AW'(det_q);
  assign emit_last = (cmd_q != sls_pkg::CMD_INVERT) || (irow_q == 2'd2) || sing_q;

  always_comb begin
    r1 = (kcol_q == 2'd0) ? 2'd1 : 2'd0;
    r2 = (kcol_q == 2'd2) ? 2'd1 : 2'd2;
    c1 = (irow_q == 2'd0) ? 2'd1 : 2'd0;
    c2 = (irow_q == 2'd2) ? 2'd1 : 2'd2;
    for (int n = 0; n < 3; n++) begin
      op_row[n] = 2'(n);
      op_col[n] = PERM[term_q][n];
      if (num_phase_q && (cmd_q == sls_pkg::CMD_SOLVE) && (op_col[n] == kcol_q)) begin
        op_col[n] = sls_pkg::COL_RHS;
      end
    end
    neg = PERM_NEG[term_q];
    if (pair) begin
      op_row[0] = r1;
      op_row[1] = r2;
      op_col[0] = term_q[0] ? c2 : c1;
      op_col[1] = term_q[0] ? c1 : c2;
      neg       = kcol_q[0] ^ irow_q[0] ^ term_q[0];
    end
  end

  always_comb begin
    unique case (state_q)
      sls_pkg::BK_RDX:  rd_addr_o = op_row[0];
      sls_pkg::BK_RDY:  rd_addr_o = op_row[1];
      sls_pkg::BK_MUL1: rd_addr_o = op_row[2];
      default:          rd_addr_o = op_row[0];
    endcase
  end

  always_comb begin
    unique case (state_q)
      sls_pkg::BK_RDY:  pick_col = op_col[0];
      sls_pkg::BK_MUL1: pick_col = op_col[1];
      default:          pick_col = op_col[2];
    endcase
    unique case (pick_col)
      2'd0:    pick = rd_data_i.c0;
      2'd1:    pick = rd_data_i.c1;
      2'd2:    pick = rd_data_i.c2;
      default: pick = rd_data_i.rhs;
    endcase
  end

  always_comb begin
    unique case (state_q)
      sls_pkg::BK_MUL2: begin
        mul_a = (FW+1)'($signed(p_q[2*FW-1:FW]));
        mul_b = (FW+1)'(pick);
      end
      sls_pkg::BK_MUL3: begin
        mul_a = {1'b0, p_q[FW-1:0]};
        mul_b = opa_q;
      end
      default: begin
        mul_a = opa_q;
        mul_b = (FW+1)'(pick);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    unique case (state_q)
      sls_pkg::BK_ACC2: addend = AW'(m_q) <<< FW;
      sls_pkg::BK_ACC3: addend = AW'(m_q);
      default:          addend = AW'(p_q);
    endcase
  end

  always_comb begin
    div_sat = sls_pkg::sat_mag(div_rsp_i.quo, acc_q[AW-1] ^ det_q[AW-1]);
    det_sat = sls_pkg::sat_mag(sls_pkg::NUM_W'(abs_det >> (2 * sls_pkg::FRAC_BITS)),
                               det_q[AW-1]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sls_pkg::BK_IDLE:  if (job_i.valid) state_d = sls_pkg::BK_RDX;
      sls_pkg::BK_RDX:   state_d = sls_pkg::BK_RDY;
      sls_pkg::BK_RDY:   state_d = sls_pkg::BK_MUL1;
      sls_pkg::BK_MUL1:  state_d = pair ? sls_pkg::BK_ACCP : sls_pkg::BK_MUL2;
      sls_pkg::BK_MUL2:  state_d = sls_pkg::BK_ACC2;
      sls_pkg::BK_ACC2:  state_d = sls_pkg::BK_MUL3;
      sls_pkg::BK_MUL3:  state_d = sls_pkg::BK_ACC3;
      sls_pkg::BK_ACC3:  state_d = sls_pkg::BK_TERM;
      sls_pkg::BK_ACCP:  state_d = sls_pkg::BK_TERM;
      sls_pkg::BK_TERM: begin
        if (!last_term)       state_d = sls_pkg::BK_RDX;
        else if (num_phase_q) state_d = sls_pkg::BK_DIV;
        else                  state_d = sls_pkg::BK_CHECK;
      end
      sls_pkg::BK_CHECK: begin
        if ((cmd_q == sls_pkg::CMD_DET) || (det_q == '0)) state_d = sls_pkg::BK_EMIT;
        else                                              state_d = sls_pkg::BK_RDX;
      end
      sls_pkg::BK_DIV:   state_d = sls_pkg::BK_DIVW;
      sls_pkg::BK_DIVW:  if (div_rsp_i.done) state_d = sls_pkg::BK_STORE;
      sls_pkg::BK_STORE: state_d = (kcol_q == 2'd2) ? sls_pkg::BK_EMIT : sls_pkg::BK_RDX;
      sls_pkg::BK_EMIT:  state_d = emit_last ? sls_pkg::BK_IDLE : sls_pkg::BK_RDX;
      default:           state_d = sls_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o           = (state_q == sls_pkg::BK_IDLE) && job_i.valid;
    busy_o          = (state_q != sls_pkg::BK_IDLE);
    div_req_o.start = (state_q == sls_pkg::BK_DIV);
    div_req_o.num   = sls_pkg::NUM_W'(abs_acc) <<
                      ((cmd_q == sls_pkg::CMD_SOLVE) ? sls_pkg::FRAC_BITS
                                                     : 2 * sls_pkg::FRAC_BITS);
    div_req_o.den   = abs_det;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sls_pkg::BK_IDLE;
      strobe_q    <= 1'b0;
      cmd_q       <= sls_pkg::CMD_SOLVE;
      num_phase_q <= 1'b0;
      sing_q      <= 1'b0;
      term_q      <= '0;
      kcol_q      <= '0;
      irow_q      <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == sls_pkg::BK_EMIT);
      unique case (state_q)
        sls_pkg::BK_IDLE: begin
          if (job_i.valid) begin
            cmd_q       <= job_i.cmd;
            num_phase_q <= 1'b0;
            sing_q      <= 1'b0;
            term_q      <= '0;
            kcol_q      <= '0;
            irow_q      <= '0;
          end
        end
        sls_pkg::BK_TERM: begin
          if (!last_term) term_q <= term_q + 3'd1;
        end
        sls_pkg::BK_CHECK: begin
          term_q      <= '0;
          num_phase_q <= 1'b1;
          sing_q      <= (cmd_q != sls_pkg::CMD_DET) && (det_q == '0);
        end
        sls_pkg::BK_STORE: begin
          term_q <= '0;
          if (kcol_q != 2'd2) kcol_q <= kcol_q + 2'd1;
        end
        sls_pkg::BK_EMIT: begin
          term_q <= '0;
          kcol_q <= '0;
          if (!emit_last) irow_q <= irow_q + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sls_pkg::BK_IDLE: begin
        acc_q  <= '0;
        flag_q <= 1'b0;
        for (int n = 0; n < 3; n++) vals_q[n] <= '0;
      end
      sls_pkg::BK_RDY:  opa_q <= (FW+1)'(pick);
      sls_pkg::BK_MUL1: p_q <= (2*FW)'(mul_p);
      sls_pkg::BK_MUL2: begin
        m_q   <= mul_p;
        opa_q <= (FW+1)'(pick);
      end
      sls_pkg::BK_MUL3: m_q <= mul_p;
      sls_pkg::BK_ACC2, sls_pkg::BK_ACC3, sls_pkg::BK_ACCP: begin
        acc_q <= neg ? acc_q - addend : acc_q + addend;
      end
      sls_pkg::BK_TERM: begin
        if (last_term && !num_phase_q) det_q <= acc_q;
      end
      sls_pkg::BK_CHECK: begin
        acc_q <= '0;
        if (cmd_q == sls_pkg::CMD_DET) begin
          vals_q[0] <= det_sat.value;
          flag_q    <= det_sat.flag;
        end
      end
      sls_pkg::BK_STORE: begin
        acc_q          <= '0;
        vals_q[kcol_q] <= div_sat.value;
        flag_q         <= flag_q | div_sat.flag;
      end
      sls_pkg::BK_EMIT: begin
        res_q.value0      <= sing_q ? '0 : vals_q[0];
        res_q.value1      <= sing_q ? '0 : vals_q[1];
        res_q.value2      <= sing_q ? '0 : vals_q[2];
        res_q.status      <= sing_q ? sls_pkg::STAT_SINGULAR :
                             flag_q ? sls_pkg::STAT_SAT : sls_pkg::STAT_OK;
        res_q.last_result <= emit_last;
        flag_q            <= 1'b0;
        acc_q             <= '0;
      end
      default: begin
      end
    endcase
  end

  assign result_o = res_q;
  assign strobe_o = strobe_q;

endmodule

// ===== tb/sv/tb_linear_solver_3x3.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_solver_3x3
// checks the 3x3 solve, inverse and determinant unit row item by row item
// ----------------------------------------------------------------------------
// a behavioral predictor with wide integer arithmetic computes the expected
// results of each last row; a monitor compares every strobed result in order
// ----------------------------------------------------------------------------
module tb_linear_solver_3x3;

  localparam int WW = 200;
  typedef logic signed [WW-1:0] wide_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  sls_pkg::sls_in_t  item_i;
  logic              busy;
  sls_pkg::sls_out_t result_o;
  logic              strobe;

  linear_solver_3x3 dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .busy(busy), .result_o(result_o), .strobe(strobe)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  wide_t             mat_q[9];
  wide_t             rhs_q[3];
  int                slot_q;
  sls_pkg::sls_out_t pending_q[$];
  int                gap_pct;
  int                err_cnt;
  int                res_cnt;
  int                cmd_cnt[4];
  int                sing_cnt;
  int                sat_cnt;

  function automatic wide_t entry_of(logic [31:0] raw);
    return wide_t'($signed(sls_pkg::take_entry(raw)));
  endfunction

  function automatic wide_t det_of(wide_t m[9]);
    return m[0] * (m[4] * m[8] - m[5] * m[7]) - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
  endfunction

  function automatic wide_t quot_of(wide_t n, wide_t d);
    wide_t an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q  = an / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic [31:0] clamp(wide_t v, ref logic flag);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (sls_pkg::ENTRY_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (sls_pkg::ENTRY_WIDTH - 1));
    if (v > hi) begin
      flag = 1'b1;
      return hi[31:0];
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  task automatic predict_solution(sls_pkg::sls_in_t it);
    wide_t             d, c, m[9], t;
    sls_pkg::sls_out_t r;
    logic              flag;
    int                row;
    row = slot_q;
    mat_q[row*3]   = entry_of(it.coef_col0);
    mat_q[row*3+1] = entry_of(it.coef_col1);
    mat_q[row*3+2] = entry_of(it.coef_col2);
    rhs_q[row]     = entry_of(it.rhs_value);
    if (!it.last_row) begin
      if (slot_q < 2) slot_q++;
      return;
    end
    slot_q = 0;
    cmd_cnt[it.command]++;
    if (it.command == sls_pkg::CMD_NONE) return;
    d = det_of(mat_q);
    r = '0;
    r.last_result = 1'b1;
    flag = 1'b0;
    if (it.command == sls_pkg::CMD_DET) begin
      t = (d < 0 ? -d : d) >>> (2 * sls_pkg::FRAC_BITS);
      r.value0 = clamp(d < 0 ? -t : t, flag);
      r.status = flag ? sls_pkg::STAT_SAT : sls_pkg::STAT_OK;
      pending_q.push_back(r);
    end else if (d == 0) begin
      r.status = sls_pkg::STAT_SINGULAR;
      pending_q.push_back(r);
    end else if (it.command == sls_pkg::CMD_SOLVE) begin
      logic [31:0] v[3];
      for (int j = 0; j < 3; j++) begin
        m = mat_q;
        for (int i = 0; i < 3; i++) m[i*3+j] = rhs_q[i];
        v[j] = clamp(quot_of(det_of(m) <<< sls_pkg::FRAC_BITS, d), flag);
      end
      r.value0 = v[0]; r.value1 = v[1]; r.value2 = v[2];
      r.status = flag ? sls_pkg::STAT_SAT : sls_pkg::STAT_OK;
      pending_q.push_back(r);
    end else begin
      for (int i = 0; i < 3; i++) begin
        logic [31:0] v[3];
        flag = 1'b0;
        for (int j = 0; j < 3; j++) begin
          int r1, r2, c1, c2;
          r1 = j == 0 ? 1 : 0; r2 = j == 2 ? 1 : 2;
          c1 = i == 0 ? 1 : 0; c2 = i == 2 ? 1 : 2;
          c = mat_q[r1*3+c1] * mat_q[r2*3+c2] - mat_q[r1*3+c2] * mat_q[r2*3+c1];
          if ((i + j) % 2) c = -c;
          v[j] = clamp(quot_of(c <<< (2 * sls_pkg::FRAC_BITS), d), flag);
        end
        r.value0 = v[0]; r.value1 = v[1]; r.value2 = v[2];
        r.status = flag ? sls_pkg::STAT_SAT : sls_pkg::STAT_OK;
        r.last_result = (i == 2);
        pending_q.push_back(r);
      end
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      res_cnt++;
      if (result_o.status == sls_pkg::STAT_SINGULAR) sing_cnt++;
      if (result_o.status == sls_pkg::STAT_SAT) sat_cnt++;
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %p", result_o);
      end else begin
        sls_pkg::sls_out_t e;
        e = pending_q.pop_front();
        if (result_o !== e) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected %p actual %p", e, result_o);
        end
      end
    end
  end

  task automatic send_row(sls_pkg::sls_in_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_solution(it);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} ^ ($urandom_range(1) ? 32'hFFFFFFFF : 0);
      2: return 32'($signed($urandom_range(8))) - 4 <<< sls_pkg::FRAC_BITS;
      3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return (32'($urandom_range(16)) - 8) * 32'h4000 + $urandom_range(3);
    endcase
  endfunction

  task automatic send_system(logic [1:0] cmd, logic [31:0] m[9], logic [31:0] b[3]);
    sls_pkg::sls_in_t it;
    for (int i = 0; i < 3; i++) begin
      it.command   = (i == 2) ? cmd : 2'($urandom());
      it.coef_col0 = m[i*3]; it.coef_col1 = m[i*3+1]; it.coef_col2 = m[i*3+2];
      it.rhs_value = b[i];
      it.last_row  = (i == 2);
      send_row(it);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0]      m[9], b[3];
    sls_pkg::sls_in_t it;
    m = '{32'h10000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h40000};
    b = '{32'h30000, 32'hFFFF0000, 32'h7FFFFFFF};
    send_system(sls_pkg::CMD_SOLVE, m, b);
    send_system(sls_pkg::CMD_INVERT, m, b);
    send_system(sls_pkg::CMD_DET, m, b);
    send_system(sls_pkg::CMD_NONE, m, b);
    m = '{32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000, 1, 2, 3};
    send_system(sls_pkg::CMD_SOLVE, m, b);
    send_system(sls_pkg::CMD_INVERT, m, b);
    m = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
          32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    b = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF};
    send_system(sls_pkg::CMD_DET, m, b);
    send_system(sls_pkg::CMD_SOLVE, m, b);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_system(sls_pkg::CMD_INVERT, m, b);
    // extra rows overwrite row two, then an early last row
    for (int i = 0; i < 4; i++) begin
      it = '{command: sls_pkg::CMD_SOLVE, coef_col0: 32'h10000 << i, coef_col1: 32'h8000,
             coef_col2: 32'hFFFF0000, rhs_value: 32'h10000, last_row: 1'b0};
      send_row(it);
    end
    it.last_row = 1'b1;
    it.command  = sls_pkg::CMD_DET;
    send_row(it);
    it.command = sls_pkg::CMD_SOLVE;
    send_row(it);
    drain();
  endtask

  task automatic test_random(int n_rows, int pct);
    logic [31:0]      m[9], b[3];
    sls_pkg::sls_in_t it;
    int               sent;
    gap_pct = pct;
    sent = 0;
    while (sent < n_rows) begin
      if ($urandom_range(9) == 0) begin
        it = {2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
              1'($urandom())};
        send_row(it);
        sent++;
      end else begin
        foreach (m[k]) m[k] = rand_entry();
        foreach (b[k]) b[k] = rand_entry();
        send_system(2'($urandom_range(3) == 3 ? $urandom_range(3) : $urandom_range(2)),
                    m, b);
        sent += 3;
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0; start = 1'b0; item_i = '0;
    slot_q = 0; gap_pct = 0; err_cnt = 0; res_cnt = 0; sing_cnt = 0; sat_cnt = 0;
    cmd_cnt = '{0, 0, 0, 0};
    foreach (mat_q[k]) mat_q[k] = 0;
    foreach (rhs_q[k]) rhs_q[k] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(130, 0);
    test_random(130, 52);
    test_random(120, 10);
    test_random(130, 0);
    $display("covered %0d solve, %0d inverse, %0d determinant, %0d unused commands",
             cmd_cnt[0], cmd_cnt[1], cmd_cnt[2], cmd_cnt[3]);
    $display("checked %0d results, %0d singular, %0d saturated, %0d errors",
             res_cnt, sing_cnt, sat_cnt, err_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sls_pkg.sv
rtl/core/sls_div.sv
rtl/core/sls_front.sv
rtl/core/sls_back.sv
rtl/core/linear_solver_3x3.sv
tb/sv/tb_linear_solver_3x3.sv
